// ----- rtl/dns_service_record_classifier_top_assert.svh -----
// Assertion macros shared by the checker of the service record classifier.
// Needs nothing else; included by the checker file.
`ifndef DNS_SERVICE_RECORD_CLASSIFIER_TOP_ASSERT_SVH
`define DNS_SERVICE_RECORD_CLASSIFIER_TOP_ASSERT_SVH
// Implication checked on every edge outside reset.
`define DSRC_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Next-cycle implication checked on every edge outside reset.
`define DSRC_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

// ----- rtl/dsrc_pkg.sv -----
// Shared types and constants of the service record classifier.
// No dependencies.
package dsrc_pkg;
   localparam int COUNT_WIDTH_DEFAULT  = 16;
   localparam int OFFSET_WIDTH_DEFAULT = 17;
   localparam int OUT_COUNT_WIDTH      = 16;
   localparam int QUEUE_DEPTH          = 2;

   localparam logic [7:0] KIND_PTR = 8'd12;
   localparam logic [7:0] KIND_TXT = 8'd16;
   localparam logic [7:0] KIND_SRV = 8'd33;

   localparam int SEEN_DROP  = 0;
   localparam int SEEN_QUIC  = 1;
   localparam int SEEN_TCP   = 2;
   localparam int SEEN_UDP   = 3;
   localparam int SEEN_LOCAL = 4;

   localparam int FLAG_ANY  = 0;
   localparam int FLAG_TCP  = 1;
   localparam int FLAG_UDP  = 2;
   localparam int FLAG_QUIC = 3;

   localparam logic [15:0] PTR_TCP       = 16'hc007;
   localparam logic [15:0] PTR_UDP       = 16'hc008;
   localparam logic [15:0] PTR_ANY       = 16'hc009;
   localparam logic [15:0] PTR_DROP_TCP  = 16'hc00a;
   localparam logic [15:0] PTR_DROP_UDP  = 16'hc00b;

   typedef enum logic [4:0] {
      NS_LEN   = 5'b00001,
      NS_LABEL = 5'b00010,
      NS_PTR   = 5'b00100,
      NS_DONE  = 5'b01000,
      NS_BAD   = 5'b10000
   } name_state_type;

   // One finished record handed from the parser to the accumulator.
   typedef struct packed {
      logic       ok;
      logic [7:0] kind;
      logic [3:0] flags;
      logic       clear;
   } verdict_type;

   // Expected character of candidate label cand at position pos; zero never matches
   // because lowered input of zero is compared only within each label's length.
   function automatic logic [7:0] cand_char(input logic [2:0] cand, input logic [2:0] pos);
      logic [63:0] s;
      unique case (cand)
         3'd0: s = {"pordria", "_"};
         3'd1: s = {8'h00, "ciuqsa", "_"};
         3'd2: s = {32'h0, "pct_"};
         3'd3: s = {32'h0, "pdu_"};
         default: s = {24'h0, "lacol"};
      endcase
      return s[pos*8 +: 8];
   endfunction

   function automatic logic [5:0] cand_len(input logic [2:0] cand);
      unique case (cand)
         3'd0: return 6'd8;
         3'd1: return 6'd7;
         3'd2: return 6'd4;
         3'd3: return 6'd4;
         default: return 6'd5;
      endcase
   endfunction
endpackage

// ----- rtl/dsrc_parser.sv -----
// Front part: walks the record bytes, matches labels and forms a verdict.
// Depends on dsrc_pkg.
module dsrc_parser import dsrc_pkg::*; #(
   parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [7:0]  in_byte,
   input  logic        in_last,
   input  logic        in_clear,
   output logic        verdict_valid,
   output verdict_type verdict
);
   localparam logic [OFFSET_WIDTH-1:0] OFS_MAX = '1;

   logic [OFFSET_WIDTH-1:0] offset_ff, offset_in;
   logic [15:0]    ntl_ff, ntl_in, dlen_ff, dlen_in;
   logic [5:0]     left_ff, left_in, pos_ff, pos_in;
   logic [4:0]     live_ff, live_in, seen_ff, seen_in;
   name_state_type ns_ff, ns_in;
   logic [7:0]     phigh_ff, phigh_in, kind_ff, kind_in;
   logic [3:0]     rflags_ff, rflags_in;
   logic           clr_pend_ff, clr_pend_in;

   logic [OFFSET_WIDTH:0] p, n;
   logic [7:0]  ch;
   logic [15:0] ptrv;
   logic        ok;

   always_comb begin
      offset_in = offset_ff; ntl_in = ntl_ff; dlen_in = dlen_ff;
      left_in = left_ff; pos_in = pos_ff; live_in = live_ff; seen_in = seen_ff;
      ns_in = ns_ff; phigh_in = phigh_ff; kind_in = kind_ff; rflags_in = rflags_ff;
      clr_pend_in = clr_pend_ff;
      p = {1'b0, offset_ff};
      n = (OFFSET_WIDTH+1)'(ntl_ff);
      ch = (in_byte >= "A" && in_byte <= "Z") ? in_byte + 8'd32 : in_byte;
      ptrv = {phigh_ff, in_byte};
      ok = 1'b0;
      verdict_valid = 1'b0;
      verdict = '0;
      if (in_valid) begin
         if (p == '0) begin
            ntl_in = {8'h00, in_byte};
         end else if (p == (OFFSET_WIDTH+1)'(1)) begin
            ntl_in = {in_byte, ntl_ff[7:0]};
            if (ntl_in < 16'd2) ns_in = NS_BAD;
         end else if (p <= n) begin
            unique case (ns_ff)
               NS_LEN: begin
                  if (in_byte[7:6] != 2'b00) begin
                     if (in_byte[7:6] == 2'b11 && p + 1'b1 == n) begin
                        phigh_in = in_byte; ns_in = NS_PTR;
                     end else ns_in = NS_BAD;
                  end else if (in_byte == 8'd0) begin
                     if (p == n) begin
                        rflags_in = '0;
                        rflags_in[FLAG_TCP] = seen_ff[SEEN_DROP] & seen_ff[SEEN_TCP]
                                              & seen_ff[SEEN_LOCAL];
                        rflags_in[FLAG_UDP] = seen_ff[SEEN_DROP] & seen_ff[SEEN_UDP]
                                              & seen_ff[SEEN_LOCAL];
                        rflags_in[FLAG_ANY] = rflags_in[FLAG_TCP] | rflags_in[FLAG_UDP];
                        rflags_in[FLAG_QUIC] = seen_ff[SEEN_QUIC] & seen_ff[SEEN_UDP]
                                               & seen_ff[SEEN_LOCAL];
                        ns_in = NS_DONE;
                     end else ns_in = NS_BAD;
                  end else if (p + (OFFSET_WIDTH+1)'(in_byte) > n) begin
                     ns_in = NS_BAD;
                  end else begin
                     left_in = in_byte[5:0]; pos_in = '0;
                     for (int i = 0; i < 5; i++)
                        live_in[i] = (cand_len(3'(i)) == in_byte[5:0]);
                     ns_in = NS_LABEL;
                  end
               end
               NS_LABEL: begin
                  for (int i = 0; i < 5; i++)
                     if (live_ff[i] && (pos_ff >= 6'd8 ||
                         cand_char(3'(i), pos_ff[2:0]) != ch))
                        live_in[i] = 1'b0;
                  pos_in = pos_ff + 6'd1;
                  left_in = left_ff - 6'd1;
                  if (left_in == '0) begin
                     seen_in = seen_ff | live_in; ns_in = NS_LEN;
                  end
               end
               NS_PTR: begin
                  rflags_in = '0;
                  if (ptrv == PTR_TCP) rflags_in = 4'b0011;
                  else if (ptrv == PTR_UDP) rflags_in = 4'b0101;
                  else if (ptrv == PTR_ANY) rflags_in = 4'b0001;
                  else if (ptrv == PTR_DROP_TCP) begin
                     if (seen_ff[SEEN_DROP]) rflags_in = 4'b0011;
                  end else if (ptrv == PTR_DROP_UDP) begin
                     if (seen_ff[SEEN_DROP]) rflags_in = 4'b0101;
                     rflags_in[FLAG_QUIC] = seen_ff[SEEN_QUIC];
                  end
                  ns_in = NS_DONE;
               end
               default: ;
            endcase
         end else if (p == n + 1'b1) begin
            kind_in = in_byte;
            if (ns_ff != NS_DONE) ns_in = NS_BAD;
         end else if (p == n + 2'd2) begin
            dlen_in = {8'h00, in_byte};
         end else if (p == n + 2'd3) begin
            dlen_in = {in_byte, dlen_ff[7:0]};
         end
         if (offset_ff < OFS_MAX) offset_in = offset_ff + 1'b1;
         clr_pend_in = clr_pend_ff | in_clear;
         if (in_last) begin
            ok = (ns_ff == NS_DONE) && (offset_ff < OFS_MAX) && (p >= 2) &&
                 ((OFFSET_WIDTH+2)'(p) == (OFFSET_WIDTH+2)'(ntl_ff) + 3'd5
                  + (OFFSET_WIDTH+2)'(dlen_ff));
            verdict_valid = 1'b1;
            verdict.ok = ok; verdict.kind = kind_ff; verdict.flags = rflags_ff;
            verdict.clear = clr_pend_ff | in_clear;
            offset_in = '0; ntl_in = '0; dlen_in = '0; left_in = '0; pos_in = '0;
            live_in = '0; seen_in = '0; ns_in = NS_LEN; phigh_in = '0;
            kind_in = '0; rflags_in = '0; clr_pend_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0; ntl_ff <= '0; dlen_ff <= '0; left_ff <= '0; pos_ff <= '0;
         live_ff <= '0; seen_ff <= '0; ns_ff <= NS_LEN; phigh_ff <= '0;
         kind_ff <= '0; rflags_ff <= '0; clr_pend_ff <= 1'b0;
      end else begin
         offset_ff <= offset_in; ntl_ff <= ntl_in; dlen_ff <= dlen_in;
         left_ff <= left_in; pos_ff <= pos_in; live_ff <= live_in; seen_ff <= seen_in;
         ns_ff <= ns_in; phigh_ff <= phigh_in; kind_ff <= kind_in;
         rflags_ff <= rflags_in; clr_pend_ff <= clr_pend_in;
      end
   end
endmodule

// ----- rtl/dsrc_queue.sv -----
// Short verdict queue between the parser and the accumulator.
// Depends on dsrc_pkg.
module dsrc_queue import dsrc_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  verdict_type push_data,
   output logic        room,
   output logic        pop_valid,
   input  logic        pop,
   output verdict_type pop_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   verdict_type      mem_ff [DEPTH];
   logic [AW-1:0]    wr_ff, rd_ff;
   logic [AW:0]      cnt_ff;

   assign room      = cnt_ff != (AW+1)'(DEPTH);
   assign pop_valid = cnt_ff != '0;
   assign pop_data  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
         if (pop)  rd_ff <= (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
   end
endmodule

// ----- rtl/dsrc_accum.sv -----
// Back part: applies verdicts to the saturating counters and sticky flags.
// Depends on dsrc_pkg.
module dsrc_accum import dsrc_pkg::*; #(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  verdict_type in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [95:0] out_data
);
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
   logic [COUNT_WIDTH-1:0] tot_ff, ptr_ff, txt_ff, srv_ff, bad_ff;
   logic [COUNT_WIDTH-1:0] tot_in, ptr_in, txt_in, srv_in, bad_in;
   logic [3:0]  flags_ff, flags_in;
   logic        valid_ff;
   logic [95:0] data_ff, data_in;

   function automatic logic [COUNT_WIDTH-1:0] sat(input logic [COUNT_WIDTH-1:0] c);
      return (c < CNT_MAX) ? c + 1'b1 : c;
   endfunction

   function automatic logic [OUT_COUNT_WIDTH-1:0] low(input logic [COUNT_WIDTH-1:0] c);
      logic [31:0] w;
      w = 32'(c);
      return w[OUT_COUNT_WIDTH-1:0];
   endfunction

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      tot_in = in_data.clear ? '0 : tot_ff;
      ptr_in = in_data.clear ? '0 : ptr_ff;
      txt_in = in_data.clear ? '0 : txt_ff;
      srv_in = in_data.clear ? '0 : srv_ff;
      bad_in = in_data.clear ? '0 : bad_ff;
      flags_in = in_data.clear ? '0 : flags_ff;
      if (in_data.ok) begin
         tot_in = sat(tot_in);
         if (in_data.kind == KIND_PTR) ptr_in = sat(ptr_in);
         else if (in_data.kind == KIND_TXT) txt_in = sat(txt_in);
         else if (in_data.kind == KIND_SRV) srv_in = sat(srv_in);
         flags_in = flags_in | in_data.flags;
      end else begin
         bad_in = sat(bad_in);
      end
      data_in = {11'b0, flags_in, low(bad_in), low(srv_in), low(txt_in),
                 low(ptr_in), low(tot_in), in_data.ok};
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tot_ff <= '0; ptr_ff <= '0; txt_ff <= '0; srv_ff <= '0; bad_ff <= '0;
         flags_ff <= '0; valid_ff <= 1'b0;
      end else begin
         if (in_valid && in_ready) begin
            tot_ff <= tot_in; ptr_ff <= ptr_in; txt_ff <= txt_in;
            srv_ff <= srv_in; bad_ff <= bad_in; flags_ff <= flags_in;
            valid_ff <= 1'b1;
         end else if (out_ready) valid_ff <= 1'b0;
      end
   end
endmodule

// ----- rtl/dns_service_record_classifier_top.sv -----
// Service record classifier: byte stream in, one profile word per record out.
// Uses dsrc_pkg, dsrc_parser, dsrc_queue and dsrc_accum.
//
// The req channel carries one record byte per word, with tlast on the final
// byte and tuser set to clear the scan counters before that byte. Each record
// yields one rsp word on its final byte: record_ok, five saturating counts and
// four sticky service flags.
// Throughput is one byte per cycle while the queue has room; the parser handles
// each accepted byte as it arrives. The verdict enters a two-entry queue at the
// edge that accepts the final byte; the accumulator takes it from the queue when
// its output register is free, and rsp_tvalid is driven by that register.
// When the receiver stalls, the output register holds, the queue fills, and
// req_tready drops only when the queue has no room; then bytes wait too.
// Synchronous reset clears the parser, queue and counters; no clearing pass.
module dns_service_record_classifier_top import dsrc_pkg::*; #(
   parameter int COUNT_WIDTH  = COUNT_WIDTH_DEFAULT,
   parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // record_byte
   input  logic        req_tlast,   // last_byte
   input  logic        req_tuser,   // new_scan
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata    // record_ok, total_count, ptr_tally, txt_tally,
                                    // srv_tally, malformed_count, has_drop_any,
                                    // has_drop_tcp, has_drop_udp, has_quic, zero pad
);
   logic        vv, room, qv, qpop, acc_ready;
   verdict_type vd, qd;

   assign req_tready = room;
   assign qpop = qv && acc_ready;

   dsrc_parser #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_parser (
      .clock, .reset, .in_valid(req_tvalid && room), .in_byte(req_tdata),
      .in_last(req_tlast), .in_clear(req_tuser), .verdict_valid(vv), .verdict(vd));

   dsrc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock, .reset, .push(vv), .push_data(vd), .room(room), .pop_valid(qv),
      .pop(qpop), .pop_data(qd));

   dsrc_accum #(.COUNT_WIDTH(COUNT_WIDTH)) u_accum (
      .clock, .reset, .in_valid(qv), .in_ready(acc_ready), .in_data(qd),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(rsp_tdata));
endmodule

// ----- rtl/dsrc_checker.sv -----
// Port-level checker for the service record classifier, bound to the top.
// Uses the assertion macro header.
`include "dns_service_record_classifier_top_assert.svh"
module dsrc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata
);
   // A stalled result word keeps its value.
   `DSRC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   // A valid record never counts as malformed-only: ok means total is nonzero.
   `DSRC_ASSERT_IMPL(a_ok_total, clock, reset, rsp_tvalid && rsp_tdata[0],
      rsp_tdata[16:1] != 16'd0)
   // A udp or tcp drop flag implies the any flag.
   `DSRC_ASSERT_IMPL(a_any_flag, clock, reset, rsp_tvalid && (rsp_tdata[82] || rsp_tdata[83]),
      rsp_tdata[81])
   // A non-final byte produces no new result when the output is empty.
   `DSRC_ASSERT_NEXT(a_no_spurious, clock, reset,
      !rsp_tvalid && !(req_tvalid && req_tready && req_tlast) && $past(!rsp_tvalid)
      && $past(!(req_tvalid && req_tready && req_tlast)), !rsp_tvalid)
endmodule

bind dns_service_record_classifier_top dsrc_checker u_checker (
   .clock, .reset, .req_tvalid, .req_tready, .req_tlast, .rsp_tvalid, .rsp_tready,
   .rsp_tdata);

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the service record classifier top level.
// It depends on dsrc_pkg and dns_service_record_classifier_top. It predicts each profile word
// from the record bytes it sends and checks each word that comes back.
module tb import dsrc_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int OFS_LIMIT = (1 << OFFSET_WIDTH_DEFAULT) - 1;
   localparam logic [15:0] COUNT_TOP = 16'hffff;
   localparam int CYCLE_LIMIT = 3000000;

   typedef logic [7:0] bytes_type[$];

   typedef struct {
      logic        ok;
      logic [15:0] total;
      logic [15:0] ptr;
      logic [15:0] txt;
      logic [15:0] srv;
      logic [15:0] bad;
      logic [3:0]  flags;
   } profile_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;

   profile_type expected_profiles[$];
   int       error_count = 0;
   int       cycle_count = 0;
   bit       idling = 1'b1;
   int       hold_request = 0;

   // Parser state of the predictor.
   int             rec_offset;
   int             rec_ntl;
   int             rec_dlen;
   int             lab_left;
   int             lab_pos;
   logic [4:0]     lab_live;
   logic [4:0]     lab_seen;
   name_state_type rec_state;
   logic [7:0]     ptr_high;
   logic [3:0]     rec_flags;
   logic [7:0]     rec_kind;
   // Scan counters of the predictor.
   logic [15:0]    n_total, n_ptr, n_txt, n_srv, n_bad;
   logic [3:0]     svc_flags;

   dns_service_record_classifier_top u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tlast(req_tlast), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic string label_text(int i);
      case (i)
         0: return {"_air", "drop"};
         1: return "_asquic";
         2: return "_tcp";
         3: return "_udp";
         default: return "local";
      endcase
   endfunction

   function void clear_parse();
      rec_offset = 0; rec_ntl = 0; rec_dlen = 0; lab_left = 0; lab_pos = 0;
      lab_live = '0; lab_seen = '0; rec_state = NS_LEN; ptr_high = '0;
      rec_flags = '0; rec_kind = '0;
   endfunction

   function void clear_scan();
      n_total = '0; n_ptr = '0; n_txt = '0; n_srv = '0; n_bad = '0; svc_flags = '0;
   endfunction

   function logic [15:0] bump(logic [15:0] v);
      return (v == COUNT_TOP) ? v : v + 16'd1;
   endfunction

   function void parse_name_byte(int p, logic [7:0] c);
      logic [7:0]  ch;
      logic [15:0] ptr_val;
      logic [3:0]  f;
      string       s;
      f = '0;
      case (rec_state)
         NS_LEN: begin
            if (c[7:6] != 2'b00) begin
               if (c[7:6] == 2'b11 && p + 1 == rec_ntl) begin
                  ptr_high = c;
                  rec_state = NS_PTR;
               end else begin
                  rec_state = NS_BAD;
               end
            end else if (c == 8'd0) begin
               if (p == rec_ntl) begin
                  if (lab_seen[SEEN_DROP] && lab_seen[SEEN_TCP] && lab_seen[SEEN_LOCAL])
                     f[FLAG_TCP] = 1'b1;
                  if (lab_seen[SEEN_DROP] && lab_seen[SEEN_UDP] && lab_seen[SEEN_LOCAL])
                     f[FLAG_UDP] = 1'b1;
                  if (f != 0) f[FLAG_ANY] = 1'b1;
                  if (lab_seen[SEEN_QUIC] && lab_seen[SEEN_UDP] && lab_seen[SEEN_LOCAL])
                     f[FLAG_QUIC] = 1'b1;
                  rec_flags = f;
                  rec_state = NS_DONE;
               end else begin
                  rec_state = NS_BAD;
               end
            end else if (p + int'(c) > rec_ntl) begin
               rec_state = NS_BAD;
            end else begin
               lab_left = int'(c); lab_pos = 0; lab_live = '0;
               for (int i = 0; i < 5; i++)
                  if (label_text(i).len() == int'(c)) lab_live[i] = 1'b1;
               rec_state = NS_LABEL;
            end
         end
         NS_LABEL: begin
            ch = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
            for (int i = 0; i < 5; i++) begin
               s = label_text(i);
               if (lab_live[i] && (lab_pos >= s.len() || s[lab_pos] != ch))
                  lab_live[i] = 1'b0;
            end
            lab_pos = (lab_pos + 1) & 63;
            lab_left = (lab_left - 1) & 63;
            if (lab_left == 0) begin
               lab_seen = lab_seen | lab_live;
               rec_state = NS_LEN;
            end
         end
         NS_PTR: begin
            ptr_val = {ptr_high, c};
            if (ptr_val == PTR_TCP) f = 4'b0011;
            else if (ptr_val == PTR_UDP) f = 4'b0101;
            else if (ptr_val == PTR_ANY) f = 4'b0001;
            else if (ptr_val == PTR_DROP_TCP) begin
               if (lab_seen[SEEN_DROP]) f = 4'b0011;
            end else if (ptr_val == PTR_DROP_UDP) begin
               if (lab_seen[SEEN_DROP]) f = f | 4'b0101;
               if (lab_seen[SEEN_QUIC]) f[FLAG_QUIC] = 1'b1;
            end
            rec_flags = f;
            rec_state = NS_DONE;
         end
         default: ;
      endcase
   endfunction

   // Advances the predictor by one byte; returns 1 when the byte ends a record.
   function bit classify_byte(logic [7:0] c, bit last, bit scan_clear, output profile_type r);
      int p, n;
      bit ok;
      p = rec_offset;
      n = rec_ntl;
      r = '{default: '0};
      if (scan_clear) clear_scan();
      if (p == 0) begin
         rec_ntl = int'(c);
      end else if (p == 1) begin
         rec_ntl = rec_ntl | (int'(c) << 8);
         if (rec_ntl < 2) rec_state = NS_BAD;
      end else if (p <= n) begin
         if (rec_state != NS_BAD && rec_state != NS_DONE) parse_name_byte(p, c);
      end else if (p == n + 1) begin
         rec_kind = c;
         if (rec_state != NS_DONE) rec_state = NS_BAD;
      end else if (p == n + 2) begin
         rec_dlen = int'(c);
      end else if (p == n + 3) begin
         rec_dlen = rec_dlen | (int'(c) << 8);
      end
      if (rec_offset < OFS_LIMIT) rec_offset++;
      if (!last) return 1'b0;
      ok = rec_state == NS_DONE && p < OFS_LIMIT && p >= 2 && p == rec_ntl + 5 + rec_dlen;
      if (ok) begin
         n_total = bump(n_total);
         if (rec_kind == KIND_PTR) n_ptr = bump(n_ptr);
         else if (rec_kind == KIND_TXT) n_txt = bump(n_txt);
         else if (rec_kind == KIND_SRV) n_srv = bump(n_srv);
         svc_flags = svc_flags | rec_flags;
      end else begin
         n_bad = bump(n_bad);
      end
      r.ok = ok; r.total = n_total; r.ptr = n_ptr; r.txt = n_txt; r.srv = n_srv;
      r.bad = n_bad; r.flags = svc_flags;
      clear_parse();
      return 1'b1;
   endfunction

   // Receiver: random stall bursts, and long hold-offs on request.
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            n = hold_request;
            hold_request = 0;
         end else if (idling && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 5);
         end else begin
            n = 0;
         end
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Compares every accepted profile word with the oldest prediction.
   always @(posedge clock) begin
      profile_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_profiles.size() == 0) begin
            $error("profile word with no prediction waiting: %h", rsp_tdata);
            error_count++;
         end else begin
            e = expected_profiles.pop_front();
            if (rsp_tdata[0] !== e.ok) begin
               $error("record_ok expected %0d actual %0d", e.ok, rsp_tdata[0]);
               error_count++;
            end
            if (rsp_tdata[16:1] !== e.total) begin
               $error("total_count expected %0d actual %0d", e.total, rsp_tdata[16:1]);
               error_count++;
            end
            if (rsp_tdata[32:17] !== e.ptr) begin
               $error("ptr_tally expected %0d actual %0d", e.ptr, rsp_tdata[32:17]);
               error_count++;
            end
            if (rsp_tdata[48:33] !== e.txt) begin
               $error("txt_tally expected %0d actual %0d", e.txt, rsp_tdata[48:33]);
               error_count++;
            end
            if (rsp_tdata[64:49] !== e.srv) begin
               $error("srv_tally expected %0d actual %0d", e.srv, rsp_tdata[64:49]);
               error_count++;
            end
            if (rsp_tdata[80:65] !== e.bad) begin
               $error("malformed_count expected %0d actual %0d", e.bad, rsp_tdata[80:65]);
               error_count++;
            end
            if (rsp_tdata[81] !== e.flags[FLAG_ANY]) begin
               $error("has_drop_any expected %0d actual %0d", e.flags[FLAG_ANY], rsp_tdata[81]);
               error_count++;
            end
            if (rsp_tdata[82] !== e.flags[FLAG_TCP]) begin
               $error("has_drop_tcp expected %0d actual %0d", e.flags[FLAG_TCP], rsp_tdata[82]);
               error_count++;
            end
            if (rsp_tdata[83] !== e.flags[FLAG_UDP]) begin
               $error("has_drop_udp expected %0d actual %0d", e.flags[FLAG_UDP], rsp_tdata[83]);
               error_count++;
            end
            if (rsp_tdata[84] !== e.flags[FLAG_QUIC]) begin
               $error("has_quic expected %0d actual %0d", e.flags[FLAG_QUIC], rsp_tdata[84]);
               error_count++;
            end
            if (rsp_tdata[95:85] !== '0) begin
               $error("pad expected 0 actual %h", rsp_tdata[95:85]);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send_byte(logic [7:0] c, bit last, bit scan_clear);
      profile_type r;
      if (idling && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tlast <= last;
      req_tuser <= scan_clear;
      do @(posedge clock); while (!req_tready);
      if (classify_byte(c, last, scan_clear, r)) expected_profiles.push_back(r);
   endtask

   task automatic send_record(bytes_type b, bit scan_clear = 1'b0);
      foreach (b[i]) send_byte(b[i], i == b.size() - 1, scan_clear && i == 0);
   endtask

   // Stops sending and waits until every predicted word has been checked.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_profiles.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   function automatic bytes_type make_record(bytes_type name, logic [7:0] kind, int dlen);
      bytes_type b;
      int ntl;
      ntl = name.size() + 1;
      b.push_back(ntl[7:0]);
      b.push_back(ntl[15:8]);
      foreach (name[i]) b.push_back(name[i]);
      b.push_back(kind);
      b.push_back(dlen[7:0]);
      b.push_back(dlen[15:8]);
      repeat (2 + dlen) b.push_back(8'($urandom));
      return b;
   endfunction

   // Length byte and text of one known label, with random letter case when asked.
   function automatic bytes_type known_label(int i, bit mix_case);
      bytes_type b;
      string s;
      logic [7:0] ch;
      s = label_text(i);
      b.push_back(8'(s.len()));
      for (int k = 0; k < s.len(); k++) begin
         ch = s[k];
         if (mix_case && ch >= "a" && ch <= "z" && $urandom_range(0, 1)) ch = ch - 8'd32;
         b.push_back(ch);
      end
      return b;
   endfunction

   function automatic bytes_type join_labels(bytes_type a, bytes_type b);
      foreach (b[i]) a.push_back(b[i]);
      return a;
   endfunction

   function automatic bytes_type random_name();
      bytes_type name;
      int len;
      repeat ($urandom_range(0, 4)) begin
         if ($urandom_range(0, 2) != 0) begin
            name = join_labels(name, known_label($urandom_range(0, 4), $urandom_range(0, 1)));
         end else begin
            len = $urandom_range(1, 12);
            name.push_back(8'(len));
            repeat (len) name.push_back(8'($urandom_range(33, 126)));
         end
      end
      case ($urandom_range(0, 2))
         0: name.push_back(8'h00);
         1: begin
            name.push_back(8'hc0);
            name.push_back(8'($urandom_range(7, 11)));
         end
         default: begin
            name.push_back(8'($urandom_range(192, 255)));
            name.push_back(8'($urandom));
         end
      endcase
      return name;
   endfunction

   function automatic logic [7:0] random_kind();
      case ($urandom_range(0, 3))
         0: return KIND_PTR;
         1: return KIND_TXT;
         2: return KIND_SRV;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic test_directed();
      bytes_type name, b;
      // Root name only, each counted type.
      name = '{8'h00};
      send_record(make_record(name, KIND_PTR, 0));
      send_record(make_record(name, KIND_TXT, 1));
      send_record(make_record(name, KIND_SRV, 3));
      // Zero-terminated names setting each service flag.
      name = join_labels(join_labels(known_label(0, 0), known_label(2, 0)), known_label(4, 0));
      name.push_back(8'h00);
      send_record(make_record(name, KIND_SRV, 2));
      name = join_labels(join_labels(known_label(0, 1), known_label(3, 1)), known_label(4, 1));
      name.push_back(8'h00);
      send_record(make_record(name, KIND_TXT, 0), 1'b1);
      name = join_labels(join_labels(known_label(1, 1), known_label(3, 0)), known_label(4, 1));
      name.push_back(8'h00);
      send_record(make_record(name, KIND_PTR, 0), 1'b1);
      // Compression pointers, with and without the labels they depend on.
      for (int v = 7; v <= 12; v++) begin
         name = join_labels(known_label(0, 0), known_label(1, 0));
         name.push_back(8'hc0);
         name.push_back(8'(v));
         send_record(make_record(name, KIND_PTR, 0), 1'b1);
      end
      name = '{8'hc0, 8'h0b};
      send_record(make_record(name, KIND_PTR, 0), 1'b1);
      name = '{8'hff, 8'hff};
      send_record(make_record(name, 8'hff, 0));
      // Length field too short, and records ending early or late.
      send_record('{8'h01, 8'h00, 8'h0c, 8'h00, 8'h00, 8'h00, 8'h00});
      send_record('{8'h05});
      send_record('{8'h02, 8'h00});
      b = make_record('{8'h00}, KIND_PTR, 2);
      b.push_back(8'h55);
      send_record(b);
      b = make_record('{8'h00}, KIND_PTR, 2);
      void'(b.pop_back());
      send_record(b);
      // Bad label bytes: top bits 01 and 10, zero and pointer too early, overrun.
      send_record(make_record('{8'h40, 8'h00}, KIND_PTR, 0));
      send_record(make_record('{8'h80, 8'h00}, KIND_PTR, 0));
      send_record(make_record('{8'h00, 8'h00}, KIND_PTR, 0));
      send_record(make_record('{8'hc0, 8'h07, 8'h00}, KIND_PTR, 0));
      send_record(make_record('{8'h05, 8'h61, 8'h00}, KIND_PTR, 0));
      // Name that runs out after a full label.
      send_record(make_record(known_label(2, 0), KIND_SRV, 0));
      // Scan cleared in the middle of a record.
      b = make_record(random_name(), KIND_TXT, 1);
      foreach (b[i]) send_byte(b[i], i == b.size() - 1, i == 3);
      // Name long enough to use the upper length byte, maximum label size.
      name = {};
      repeat (4) begin
         name.push_back(8'd63);
         repeat (63) name.push_back(8'($urandom_range(0, 255)));
      end
      name.push_back(8'h00);
      send_record(make_record(name, KIND_SRV, 0));
      drain();
   endtask

   task automatic test_pressure();
      hold_request = 300;
      repeat (12) send_record(make_record('{8'h00}, random_kind(), 0));
      drain();
   endtask

   task automatic test_random(int count);
      bytes_type b;
      int sent, pos;
      sent = 0;
      while (sent < count) begin
         if (count - sent < 150) idling = 1'b0;
         case ($urandom_range(0, 9))
            0: begin
               b = {};
               repeat ($urandom_range(1, 12)) b.push_back(8'($urandom));
            end
            1, 2: begin
               b = make_record(random_name(), random_kind(), $urandom_range(0, 6));
               pos = $urandom_range(0, b.size() - 1);
               case ($urandom_range(0, 2))
                  0: b[pos] = 8'($urandom);
                  1: void'(b.pop_back());
                  default: b.push_back(8'($urandom));
               endcase
               if (b.size() == 0) b.push_back(8'($urandom));
            end
            default: b = make_record(random_name(), random_kind(), $urandom_range(0, 6));
         endcase
         foreach (b[i]) send_byte(b[i], i == b.size() - 1, $urandom_range(0, 60) == 0);
         sent += b.size();
      end
      drain();
   endtask

   initial begin
      clear_parse();
      clear_scan();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_pressure();
      test_random(630);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/dsrc_pkg.sv
rtl/dsrc_parser.sv
rtl/dsrc_queue.sv
rtl/dsrc_accum.sv
rtl/dns_service_record_classifier_top.sv
rtl/dsrc_checker.sv
tb/sv/tb.sv
